/* rtl/core/bfa_pkg.sv */
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int BITS_PER_WORD = 8 * 4;
  localparam int WORD_BITS     = 5;
  // Frame numbers are 16 bits, so no more than 65536 frames are ever searched.
  localparam int FRAME_LIMIT   = 32'h1000 * 16;
  localparam int SCAN_CW       = 12;

  localparam logic [16:0] FRAMES_RESET = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOOP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_WR,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

/* rtl/core/bfa_if.sv */
// Channel interfaces: request items, result items and the configuration write.
`timescale 1ns / 1ps

interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] current_frame;
  logic        kernel_page;
  logic        page_rw;

  modport source (output valid, operation, current_frame, kernel_page, page_rw,
                  input ready);
  modport sink   (input valid, operation, current_frame, kernel_page, page_rw,
                  output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_number;
  logic        present_bit;
  logic        writable_bit;
  logic        user_bit;
  logic [1:0]  status;

  modport source (output valid, frame_number, present_bit, writable_bit, user_bit, status,
                  input ready);
  modport sink   (input valid, frame_number, present_bit, writable_bit, user_bit, status,
                  output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] frames_in_use;

  modport source (output valid, frames_in_use, input ready);
  modport sink   (input valid, frames_in_use, output ready);
endinterface

/* rtl/core/bitmap_frame_allocator_top.sv */
// Bitmap physical frame allocator: used-frame bitmap in a word memory, scanned per alloc.
//
// Channels: req takes one item (alloc or free), rsp returns exactly one item per
// request, cfg writes frames_in_use; cfg.ready stays high, so write only while no
// item is in flight.
// The bitmap lives in one memory of ceil(MAX_FRAMES/32) 32-bit words with a
// registered read port; frame f sits in word f/32, bit f%32.
// Steps from acceptance to rsp.valid:
//   no-op requests and out-of-range frees: the result is loaded into the output register
//   free: read, then write back the word
//   alloc: the scan reads one word per cycle, from word 0 up to the first word with a
//   clear bit, or through words_searched words when nothing is free (none when that is 0).
// One item is in work at a time; the next item is accepted once the previous
// result sits in the output register, even while rsp is stalled.
// Reset: the block sweeps the memory to zero, one word per cycle, over all
// ceil(MAX_FRAMES/32) words with req.ready low; cfg is accepted throughout.
// frames_in_use resets to 65536.
// A stalled rsp holds its item; a finished item waits until the output frees.
`timescale 1ns / 1ps

module bitmap_frame_allocator_top #(
  parameter int MAX_FRAMES = 65536
) (
  input logic       clk,
  input logic       rst,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp,
  bfa_cfg_if.sink   cfg
);

  localparam int WORDS = (MAX_FRAMES + bfa_pkg::BITS_PER_WORD - 1) / bfa_pkg::BITS_PER_WORD;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SEARCH_LIMIT =
    (MAX_FRAMES < bfa_pkg::FRAME_LIMIT) ? MAX_FRAMES : bfa_pkg::FRAME_LIMIT;
  localparam logic [AW-1:0] LAST_WORD      = AW'(WORDS - 1);
  localparam logic [16:0]   SEARCH_LIMIT_V = 17'(SEARCH_LIMIT);
  localparam logic [31:0]   MAX_FRAMES_V   = 32'(MAX_FRAMES);

  bfa_pkg::state_t state, state_next;

  logic [16:0]   frames_in_use;
  logic [AW-1:0] clr_addr;

  // latched request
  logic          req_op_q;
  logic [15:0]   req_cur_q;
  logic          req_kern_q;
  logic          req_wr_q;
  logic [AW-1:0] req_word_q;

  // scan pipeline
  logic [bfa_pkg::SCAN_CW-1:0] issue_idx;
  logic [bfa_pkg::SCAN_CW-1:0] pend_idx;
  logic                        pend_valid;

  // bitmap memory
  logic [31:0]   mem [WORDS];
  logic [31:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   wr_data;

  // finished result, then output register
  logic [15:0] res_frame;
  logic        res_present;
  logic        res_writable;
  logic        res_user;
  logic [1:0]  res_status;

  logic        out_valid;
  logic [15:0] out_frame;
  logic        out_present;
  logic        out_writable;
  logic        out_user;
  logic [1:0]  out_status;

  logic                        accept;
  logic                        req_ready;
  logic [16:0]                 frames_clamped;
  logic [bfa_pkg::SCAN_CW-1:0] search_words;
  logic                        scan_more;
  logic                        found;
  logic [31:0]                 free_mask;
  logic [31:0]                 low_one;
  logic [4:0]                  low_bit;
  logic [31:0]                 in_word_ext;
  logic [31:0]                 issue_ext;
  logic [31:0]                 pend_ext;
  logic                        in_range;
  logic                        emit_load;

  assign accept = req.valid && req_ready;

  assign frames_clamped = (frames_in_use > SEARCH_LIMIT_V) ? SEARCH_LIMIT_V : frames_in_use;
  assign search_words   = frames_clamped[16:bfa_pkg::WORD_BITS];
  assign scan_more      = issue_idx < search_words;

  assign found     = pend_valid && (rd_data != '1);
  assign free_mask = ~rd_data;
  assign low_one   = free_mask & (~free_mask + 32'd1);

  // encode the one-hot lowest clear bit
  always_comb begin
    low_bit = '0;
    for (int i = 0; i < bfa_pkg::BITS_PER_WORD; i++) begin
      if (low_one[i]) begin
        low_bit = low_bit | 5'(i);
      end
    end
  end

  assign in_word_ext = 32'(req.current_frame[15:bfa_pkg::WORD_BITS]);
  assign issue_ext   = 32'(issue_idx);
  assign pend_ext    = 32'(pend_idx);
  assign in_range    = 32'(req.current_frame) < MAX_FRAMES_V;
  assign emit_load   = (state == bfa_pkg::S_EMIT) && (!out_valid || rsp.ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfa_pkg::S_CLEAR: begin
        if (clr_addr == LAST_WORD) state_next = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          if (req.operation == bfa_pkg::OP_FREE && req.current_frame != '0 && in_range) begin
            state_next = bfa_pkg::S_FREE_WR;
          end else if (req.operation == bfa_pkg::OP_ALLOC && req.current_frame == '0) begin
            state_next = bfa_pkg::S_SCAN;
          end else begin
            state_next = bfa_pkg::S_EMIT;
          end
        end
      end
      bfa_pkg::S_FREE_WR: state_next = bfa_pkg::S_EMIT;
      bfa_pkg::S_SCAN: begin
        if (found || (!pend_valid && !scan_more)) state_next = bfa_pkg::S_EMIT;
      end
      bfa_pkg::S_EMIT: begin
        if (!out_valid || rsp.ready) state_next = bfa_pkg::S_IDLE;
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    wr_addr   = clr_addr;
    wr_data   = '0;
    rd_addr   = issue_ext[AW-1:0];
    unique case (state)
      bfa_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      bfa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = in_word_ext[AW-1:0];
      end
      bfa_pkg::S_FREE_WR: begin
        mem_we  = 1'b1;
        wr_addr = req_word_q;
        wr_data = rd_data & ~(32'd1 << req_cur_q[bfa_pkg::WORD_BITS-1:0]);
      end
      bfa_pkg::S_SCAN: begin
        mem_we  = found;
        wr_addr = pend_ext[AW-1:0];
        wr_data = rd_data | low_one;
      end
      bfa_pkg::S_EMIT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= bfa_pkg::FRAMES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      frames_in_use <= cfg.frames_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == bfa_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == bfa_pkg::S_SCAN) begin
      pend_valid <= scan_more && !found;
    end else begin
      pend_valid <= 1'b0;
    end
  end

  // request latch and result build
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_q     <= req.operation;
      req_cur_q    <= req.current_frame;
      req_kern_q   <= req.kernel_page;
      req_wr_q     <= req.page_rw;
      req_word_q   <= in_word_ext[AW-1:0];
      issue_idx    <= '0;
      res_present  <= 1'b0;
      res_writable <= 1'b0;
      res_user     <= 1'b0;
      if (req.operation == bfa_pkg::OP_ALLOC) begin
        if (req.current_frame != '0) begin
          res_frame  <= req.current_frame;
          res_status <= bfa_pkg::ST_NOOP;
        end else begin
          res_frame  <= '0;
          res_status <= bfa_pkg::ST_FULL;
        end
      end else begin
        res_frame  <= '0;
        res_status <= (req.current_frame == '0) ? bfa_pkg::ST_NOOP : bfa_pkg::ST_DONE;
      end
    end else if (state == bfa_pkg::S_SCAN) begin
      pend_idx <= issue_idx;
      if (scan_more) issue_idx <= issue_idx + 1'b1;
      if (found) begin
        res_frame    <= {pend_idx[10:0], low_bit};
        res_present  <= 1'b1;
        res_writable <= req_wr_q;
        res_user     <= !req_kern_q;
        res_status   <= bfa_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_frame    <= res_frame;
      out_present  <= res_present;
      out_writable <= res_writable;
      out_user     <= res_user;
      out_status   <= res_status;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_number = out_frame;
  assign rsp.present_bit  = out_present;
  assign rsp.writable_bit = out_writable;
  assign rsp.user_bit     = out_user;
  assign rsp.status       = out_status;

`ifndef SYNTHESIS
  a_found_emits: assert property (@(posedge clk) disable iff (rst)
    (state == bfa_pkg::S_SCAN && found) |=> state == bfa_pkg::S_EMIT)
    else $error("scan hit did not move to emit");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != bfa_pkg::S_IDLE)
    else $error("accepted item left no work");

  a_present_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.present_bit) |-> rsp.status == bfa_pkg::ST_DONE)
    else $error("present flag without done status");

  a_free_op_write: assert property (@(posedge clk) disable iff (rst)
    (state == bfa_pkg::S_FREE_WR) |-> (req_op_q == bfa_pkg::OP_FREE && req_cur_q != '0))
    else $error("free write-back for a non-free item");
`endif

endmodule

/* tb/bfa_checker.sv */
// Checker for the bitmap frame allocator: tracks the used-frame map and compares result items.
`timescale 1ns / 1ps

module bfa_checker #(
  parameter int MAX_FRAMES = 65536
) (
  input  logic clk,
  input  logic rst,
  bfa_req_if   req,
  bfa_rsp_if   rsp,
  bfa_cfg_if   cfg,
  output int   errors,
  output int   outstanding
);

  localparam int MAP_WORDS =
    (MAX_FRAMES + bfa_pkg::BITS_PER_WORD - 1) / bfa_pkg::BITS_PER_WORD;

  typedef struct packed {
    logic [15:0] frame_number;
    logic        present_bit;
    logic        writable_bit;
    logic        user_bit;
    logic [1:0]  status;
  } page_result_t;

  logic [31:0]  used_map [MAP_WORDS];
  logic [16:0]  managed_frames;
  page_result_t pending_pages [$];

  // Whole words below the managed count, after saturation.
  function automatic int searched_words();
    int n;
    n = int'(managed_frames);
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    if (n > bfa_pkg::FRAME_LIMIT) n = bfa_pkg::FRAME_LIMIT;
    return n / bfa_pkg::BITS_PER_WORD;
  endfunction

  // Applies one request to the map and returns the page entry it produces.
  function automatic page_result_t predict_page(input logic op, input logic [15:0] cur,
                                                input logic kern, input logic wr);
    page_result_t r;
    int words;
    bit found;
    r = '0;
    found = 1'b0;
    if (op == bfa_pkg::OP_ALLOC) begin
      if (cur != 16'd0) begin
        r.frame_number = cur;
        r.status = bfa_pkg::ST_NOOP;
      end else begin
        words = searched_words();
        for (int w = 0; w < words && w < MAP_WORDS && !found; w++) begin
          if (used_map[w] != '1) begin
            for (int b = 0; b < bfa_pkg::BITS_PER_WORD && !found; b++) begin
              if (!used_map[w][b]) begin
                found = 1'b1;
                used_map[w][b] = 1'b1;
                r.frame_number = 16'(w * bfa_pkg::BITS_PER_WORD + b);
                r.present_bit = 1'b1;
                r.writable_bit = wr;
                r.user_bit = ~kern;
                r.status = bfa_pkg::ST_DONE;
              end
            end
          end
        end
        if (!found) r.status = bfa_pkg::ST_FULL;
      end
    end else begin
      if (cur == 16'd0) begin
        r.status = bfa_pkg::ST_NOOP;
      end else begin
        if (int'(cur) < MAX_FRAMES) used_map[cur[15:5]][cur[4:0]] = 1'b0;
        r.status = bfa_pkg::ST_DONE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    page_result_t got_page, want_page;
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;
      managed_frames = bfa_pkg::FRAMES_RESET;
      pending_pages.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) managed_frames = cfg.frames_in_use;
      // Results first: a result never belongs to an item accepted on the same edge.
      if (rsp.valid && rsp.ready) begin
        got_page = '{rsp.frame_number, rsp.present_bit, rsp.writable_bit, rsp.user_bit,
                     rsp.status};
        if (pending_pages.size() == 0) begin
          report_mismatch($sformatf("result item with no request waiting: %h", got_page));
        end else begin
          want_page = pending_pages.pop_front();
          check_field("frame_number", got_page.frame_number, want_page.frame_number);
          check_field("present_bit", 16'(got_page.present_bit), 16'(want_page.present_bit));
          check_field("writable_bit", 16'(got_page.writable_bit),
                      16'(want_page.writable_bit));
          check_field("user_bit", 16'(got_page.user_bit), 16'(want_page.user_bit));
          check_field("status", 16'(got_page.status), 16'(want_page.status));
        end
      end
      if (req.valid && req.ready)
        pending_pages.push_back(predict_page(req.operation, req.current_frame,
                                             req.kernel_page, req.page_rw));
    end
    outstanding <= pending_pages.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the bitmap frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending_count;
  bit   quiet;
  int   sent_items;
  int   settings_used;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();
  bfa_cfg_if cfg_ch ();

  bitmap_frame_allocator_top #(.MAX_FRAMES(65536)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  bfa_checker #(.MAX_FRAMES(65536)) chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (fail_count),
    .outstanding (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_page(input logic op, input logic [15:0] cur, input logic kern,
                           input logic wr);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.operation = op;
    req_ch.current_frame = cur;
    req_ch.kernel_page = kern;
    req_ch.page_rw = wr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Only written once every result is back.
  task automatic set_frames(input logic [16:0] value);
    req_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.frames_in_use = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings_used++;
  endtask

  // Mostly allocs of empty pages and frees of frames 1 to free_span; rest is noise.
  task automatic random_page(input int free_span);
    int r;
    logic [15:0] cur;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'($urandom), 1'($urandom));
    end else if (r < 85) begin
      send_page(bfa_pkg::OP_FREE, 16'($urandom_range(1, free_span)), 1'($urandom),
                1'($urandom));
    end else begin
      cur = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      send_page(1'($urandom), cur, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    stall = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall > 0 && !quiet) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
      end
      @(negedge clk);
    end
  end

  logic [16:0] phase_frames [7] = '{17'd32, 17'd64, 17'h1FFFF, 17'd40, 17'd100, 17'd0,
                                    17'h10000};
  int          phase_items  [7] = '{50, 45, 45, 45, 45, 10, 50};

  initial begin
    int managed;
    int free_span;
    rst = 1'b1;
    quiet = 1'b0;
    sent_items = 0;
    settings_used = 0;
    req_ch.valid = 1'b0;
    req_ch.operation = bfa_pkg::OP_ALLOC;
    req_ch.current_frame = 16'd0;
    req_ch.kernel_page = 1'b0;
    req_ch.page_rw = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.frames_in_use = bfa_pkg::FRAMES_RESET;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset frame count; frame zero is handed out first.
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b0, 1'b1);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b1, 1'b0);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b0, 1'b0);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b1, 1'b1);
    send_page(bfa_pkg::OP_ALLOC, 16'hFFFF, 1'b1, 1'b1);
    send_page(bfa_pkg::OP_ALLOC, 16'd2, 1'b0, 1'b1);
    send_page(bfa_pkg::OP_FREE, 16'd0, 1'b1, 1'b1);
    send_page(bfa_pkg::OP_FREE, 16'd1, 1'b0, 1'b0);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b0, 1'b1);
    send_page(bfa_pkg::OP_FREE, 16'hFFFF, 1'b1, 1'b0);
    send_page(bfa_pkg::OP_FREE, 16'h8000, 1'b0, 1'b1);
    send_page(bfa_pkg::OP_FREE, 16'd2, 1'b1, 1'b1);
    send_page(bfa_pkg::OP_FREE, 16'd2, 1'b0, 1'b0);
    // Counts below one word leave nothing to search.
    set_frames(17'd0);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b0, 1'b1);
    set_frames(17'd31);
    send_page(bfa_pkg::OP_ALLOC, 16'd0, 1'b1, 1'b0);

    for (int p = 0; p < 7; p++) begin
      set_frames(phase_frames[p]);
      quiet = ($urandom_range(0, 3) == 0);
      managed = (int'(phase_frames[p]) > 65536) ? 65536 : int'(phase_frames[p]);
      free_span = (managed > 200) ? 255 : managed + 8;
      for (int i = 0; i < phase_items[p]; i++) random_page(free_span);
    end

    quiet = 1'b0;
    req_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Summary: %0d requests over %0d frame-count settings", sent_items,
             settings_used);
    $display("Summary: fill to exhaustion, partial and sub-word counts, saturating count");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bfa_pkg.sv
rtl/core/bfa_if.sv
rtl/core/bitmap_frame_allocator_top.sv
tb/bfa_checker.sv
tb/tb_top.sv
